>>> rtl/core/rmds_pkg.sv
// ----------------------------------------------------------------------------
// rmds_pkg
// Types, constants and small helpers for the rumble motor drive scaler.
// ----------------------------------------------------------------------------
package rmds_pkg;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int DRIVE_W    = 7;
   localparam int LEVEL_W    = 16;
   localparam int POS_W      = 10;

   // shared multiply-add unit: prod = a * b + c
   localparam int MUL_A_W = 17;
   localparam int MUL_B_W = 13;
   localparam int MUL_C_W = 15;
   localparam int PROD_W  = 31;

   localparam logic [6:0]  PCT_FULL     = 7'd100;
   localparam logic [12:0] RECIP_100    = 13'd5243;   // x/100 = (x*5243) >> 19
   localparam logic [12:0] RECIP_1023   = 13'd1025;   // x/1023 ~ (x*1025) >> 20
   localparam logic [14:0] ROUND_1023   = 15'd511;
   localparam logic [14:0] ROUND_65535  = 15'd32767;
   localparam logic [7:0]  PULSE_SUSTAIN = 8'hFF;
   localparam logic [7:0]  PULSE_LOOPS   = 8'hEB;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAIN_ATT  = 2'd0,
      CSR_TRIG_ATT  = 2'd1,
      CSR_TRIG_MODE = 2'd2,
      CSR_QUIRKS    = 2'd3
   } csr_index_type;

   localparam logic [1:0] TRIG_MODE_OFF = 2'd2;

   // quirk flag bit positions
   localparam int QK_NO_PULSE = 0;
   localparam int QK_NO_TRIG  = 1;
   localparam int QK_NO_MASK  = 2;
   localparam int QK_REVERSE  = 3;
   localparam int QK_SWAP     = 4;
   localparam int QUIRK_W     = 5;

   localparam int MASK_STRONG = 3;
   localparam int MASK_WEAK   = 2;
   localparam int MASK_LEFT   = 1;
   localparam int MASK_RIGHT  = 0;

   typedef struct packed {
      logic [LEVEL_W-1:0] weak_level;
      logic [LEVEL_W-1:0] strong_level;
      logic               play;
      logic [POS_W-1:0]   left_trigger_position;
      logic [POS_W-1:0]   right_trigger_position;
   } req_item_type;

   typedef struct packed {
      logic [3:0]         motor_enable_mask;
      logic [DRIVE_W-1:0] strong_drive;
      logic [DRIVE_W-1:0] weak_drive;
      logic [DRIVE_W-1:0] left_trigger_drive;
      logic [DRIVE_W-1:0] right_trigger_drive;
      logic [7:0]         pulse_sustain;
      logic [7:0]         pulse_loops;
   } rsp_item_type;

   typedef struct packed {
      logic [DRIVE_W-1:0] strong_drv;
      logic [DRIVE_W-1:0] weak_drv;
      logic [DRIVE_W-1:0] left;
      logic [DRIVE_W-1:0] right;
   } drive_set_type;

   typedef struct packed {
      logic               en;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
      logic [MUL_C_W-1:0] c;
   } mul_op_type;

   function automatic logic [DRIVE_W-1:0] percent_of(input logic [CSR_DATA_W-1:0] att);
      logic [CSR_DATA_W-1:0] diff;
      diff = {1'b0, PCT_FULL} - att;
      return (att >= {1'b0, PCT_FULL}) ? '0 : diff[DRIVE_W-1:0];
   endfunction

   // prod = num * 1025; the estimate is exact or one low
   function automatic logic [DRIVE_W-1:0] div1023_fix(input logic [PROD_W-1:0]  prod,
                                                      input logic [MUL_A_W-1:0] num);
      logic [DRIVE_W-1:0] q0;
      logic [7:0]         q1;
      logic [17:0]        lim;
      q0  = prod[26:20];
      q1  = {1'b0, q0} + 8'd1;
      lim = {q1, 10'b0} - 18'(q1);
      return ({1'b0, num} >= lim) ? q1[DRIVE_W-1:0] : q0;
   endfunction

   // x / 65535 for x well below 2^32: x >> 16, one low at most
   function automatic logic [DRIVE_W-1:0] div65535_fix(input logic [PROD_W-1:0] x);
      logic [DRIVE_W-1:0] q0;
      logic [7:0]         q1;
      logic [23:0]        lim;
      q0  = x[22:16];
      q1  = {1'b0, q0} + 8'd1;
      lim = {q1, 16'b0} - 24'(q1);
      return (x[23:0] >= lim) ? q1[DRIVE_W-1:0] : q0;
   endfunction

endpackage

>>> rtl/core/rmds_mul.sv
// ----------------------------------------------------------------------------
// rmds_mul
// Shared multiply-add unit, one registered product per enabled cycle.
// ----------------------------------------------------------------------------
module rmds_mul (
   input  logic                       clock,
   input  rmds_pkg::mul_op_type       op,
   output logic [rmds_pkg::PROD_W-1:0] prod
);

   logic [rmds_pkg::PROD_W-1:0] prod_ff;
   logic [rmds_pkg::PROD_W-1:0] prod_in;

   assign prod_in = rmds_pkg::PROD_W'(op.a) * rmds_pkg::PROD_W'(op.b)
                  + rmds_pkg::PROD_W'(op.c);

   always_ff @(posedge clock) begin
      if (op.en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

>>> rtl/core/rmds_mask.sv
// ----------------------------------------------------------------------------
// rmds_mask
// Change detection against the shadows and quirk rewrites of the enable mask.
// ----------------------------------------------------------------------------
module rmds_mask (
   input  rmds_pkg::drive_set_type              drv,
   input  rmds_pkg::drive_set_type              shadow,
   input  logic [rmds_pkg::QUIRK_W-1:0]         quirks,
   output logic                                 changed,
   output rmds_pkg::rsp_item_type               item
);

   logic [3:0] chg;
   logic [3:0] m_base;
   logic [3:0] m_rev;
   logic [3:0] m_swap;
   logic       no_trig;

   assign no_trig = quirks[rmds_pkg::QK_NO_TRIG];

   always_comb begin
      chg                        = '0;
      chg[rmds_pkg::MASK_STRONG] = (drv.strong_drv != shadow.strong_drv);
      chg[rmds_pkg::MASK_WEAK]   = (drv.weak_drv != shadow.weak_drv);
      chg[rmds_pkg::MASK_LEFT]   = !no_trig && (drv.left != shadow.left);
      chg[rmds_pkg::MASK_RIGHT]  = !no_trig && (drv.right != shadow.right);
   end

   assign changed = |chg;

   // reverse swaps 1<->2 and 0<->3 (a bit reversal); swap does 0<->2, 1<->3
   assign m_base = quirks[rmds_pkg::QK_NO_MASK] ? 4'hF : chg;
   assign m_rev  = quirks[rmds_pkg::QK_REVERSE]
                 ? {m_base[0], m_base[1], m_base[2], m_base[3]} : m_base;
   assign m_swap = quirks[rmds_pkg::QK_SWAP]
                 ? {m_rev[1], m_rev[0], m_rev[3], m_rev[2]} : m_rev;

   always_comb begin
      item.motor_enable_mask   = m_swap;
      item.strong_drive        = drv.strong_drv;
      item.weak_drive          = drv.weak_drv;
      item.left_trigger_drive  = no_trig ? '0 : drv.left;
      item.right_trigger_drive = no_trig ? '0 : drv.right;
      item.pulse_sustain       = quirks[rmds_pkg::QK_NO_PULSE] ? '0 : rmds_pkg::PULSE_SUSTAIN;
      item.pulse_loops         = quirks[rmds_pkg::QK_NO_PULSE] ? '0 : rmds_pkg::PULSE_LOOPS;
   end

endmodule

>>> rtl/core/rumble_motor_drive_scaler_top.sv
// Flow: the idle state takes one request item, the shared multiply-add unit runs
//   10 products, the last drive is captured, and a compare step loads the result
//   if the drives changed, waiting for a free result slot; a new request item is taken only back in idle.
// The result register frees the input side while a result waits to be taken.
// Reset (synchronous, active high) clears the configuration registers, the
//   shadows and the result valid flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
// rumble_motor_drive_scaler_top
// Scales one playback item into four motor drives and a change/enable mask.
// ----------------------------------------------------------------------------
module rumble_motor_drive_scaler_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rmds_pkg::req_item_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rmds_pkg::rsp_item_type              rsp_data,
   input  logic                                csr_write_en,
   input  logic [rmds_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rmds_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   typedef enum logic [12:0] {
      ST_IDLE    = 13'b0000000000001,
      ST_PT_MUL  = 13'b0000000000010,
      ST_PT_DIV  = 13'b0000000000100,
      ST_FL_MUL  = 13'b0000000001000,
      ST_FL_DIV  = 13'b0000000010000,
      ST_FL_FIX  = 13'b0000000100000,
      ST_FR_DIV  = 13'b0000001000000,
      ST_FR_FIX  = 13'b0000010000000,
      ST_D_WEAK  = 13'b0000100000000,
      ST_D_LEFT  = 13'b0001000000000,
      ST_D_RIGHT = 13'b0010000000000,
      ST_D_LAST  = 13'b0100000000000,
      ST_DECIDE  = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [7:0]                        main_att_ff;
   logic [7:0]                        trig_att_ff;
   logic [1:0]                        trig_mode_ff;
   logic [rmds_pkg::QUIRK_W-1:0]      quirk_ff;

   logic [rmds_pkg::LEVEL_W-1:0]      weak_ff, strong_ff, max_ff;
   logic [rmds_pkg::POS_W-1:0]        pos_l_ff, pos_r_ff;
   logic [rmds_pkg::DRIVE_W-1:0]      ptrig_ff;
   logic [rmds_pkg::MUL_A_W-1:0]      num_ff;
   logic [rmds_pkg::DRIVE_W-1:0]      frac_l_ff, frac_r_ff;
   rmds_pkg::drive_set_type           drv_ff;
   rmds_pkg::drive_set_type           shadow_ff;
   logic                              rsp_valid_ff;
   rmds_pkg::rsp_item_type            rsp_data_ff;

   logic [rmds_pkg::DRIVE_W-1:0]      p_main;
   logic [rmds_pkg::DRIVE_W-1:0]      p_trig_raw;
   logic [rmds_pkg::DRIVE_W-1:0]      ptrig_now;
   logic [rmds_pkg::DRIVE_W-1:0]      frac_now;
   logic [rmds_pkg::DRIVE_W-1:0]      drive_now;
   logic [rmds_pkg::LEVEL_W-1:0]      weak_gated, strong_gated;
   logic [rmds_pkg::PROD_W-1:0]       prod;
   rmds_pkg::mul_op_type              mul_op;
   rmds_pkg::rsp_item_type            item;
   logic                              changed;
   logic                              accept;
   logic                              load;

   assign p_main     = rmds_pkg::percent_of(main_att_ff);
   assign p_trig_raw = rmds_pkg::percent_of(trig_att_ff);
   assign ptrig_now  = prod[25:19];
   assign frac_now   = (trig_mode_ff == rmds_pkg::TRIG_MODE_OFF)
                     ? '0 : rmds_pkg::div1023_fix(prod, num_ff);
   assign drive_now  = rmds_pkg::div65535_fix(prod);

   assign weak_gated   = req_data.play ? req_data.weak_level : '0;
   assign strong_gated = req_data.play ? req_data.strong_level : '0;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign load      = (state_ff == ST_DECIDE) && changed && (!rsp_valid_ff || rsp_ready);

   // operand select for the shared multiply-add
   always_comb begin
      mul_op = '0;
      unique case (state_ff)
         ST_PT_MUL: begin
            mul_op.en = 1'b1;
            mul_op.a  = rmds_pkg::MUL_A_W'(p_trig_raw);
            mul_op.b  = rmds_pkg::MUL_B_W'(p_main);
         end
         ST_PT_DIV: begin
            mul_op.en = 1'b1;
            mul_op.a  = rmds_pkg::MUL_A_W'(prod[13:0]);
            mul_op.b  = rmds_pkg::RECIP_100;
         end
         ST_FL_MUL: begin
            mul_op.en = 1'b1;
            mul_op.a  = rmds_pkg::MUL_A_W'(pos_l_ff);
            mul_op.b  = rmds_pkg::MUL_B_W'(ptrig_now);
            mul_op.c  = rmds_pkg::ROUND_1023;
         end
         ST_FL_DIV, ST_FR_DIV: begin
            mul_op.en = 1'b1;
            mul_op.a  = prod[rmds_pkg::MUL_A_W-1:0];
            mul_op.b  = rmds_pkg::RECIP_1023;
         end
         ST_FL_FIX: begin
            mul_op.en = 1'b1;
            mul_op.a  = rmds_pkg::MUL_A_W'(pos_r_ff);
            mul_op.b  = rmds_pkg::MUL_B_W'(ptrig_ff);
            mul_op.c  = rmds_pkg::ROUND_1023;
         end
         ST_FR_FIX: begin
            mul_op.en = 1'b1;
            mul_op.a  = rmds_pkg::MUL_A_W'(strong_ff);
            mul_op.b  = rmds_pkg::MUL_B_W'(p_main);
            mul_op.c  = rmds_pkg::ROUND_65535;
         end
         ST_D_WEAK: begin
            mul_op.en = 1'b1;
            mul_op.a  = rmds_pkg::MUL_A_W'(weak_ff);
            mul_op.b  = rmds_pkg::MUL_B_W'(p_main);
            mul_op.c  = rmds_pkg::ROUND_65535;
         end
         ST_D_LEFT: begin
            mul_op.en = 1'b1;
            mul_op.a  = rmds_pkg::MUL_A_W'(max_ff);
            mul_op.b  = rmds_pkg::MUL_B_W'(frac_l_ff);
            mul_op.c  = rmds_pkg::ROUND_65535;
         end
         ST_D_RIGHT: begin
            mul_op.en = 1'b1;
            mul_op.a  = rmds_pkg::MUL_A_W'(max_ff);
            mul_op.b  = rmds_pkg::MUL_B_W'(frac_r_ff);
            mul_op.c  = rmds_pkg::ROUND_65535;
         end
         default: begin
            mul_op = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (accept) state_in = ST_PT_MUL;
         ST_PT_MUL:  state_in = ST_PT_DIV;
         ST_PT_DIV:  state_in = ST_FL_MUL;
         ST_FL_MUL:  state_in = ST_FL_DIV;
         ST_FL_DIV:  state_in = ST_FL_FIX;
         ST_FL_FIX:  state_in = ST_FR_DIV;
         ST_FR_DIV:  state_in = ST_FR_FIX;
         ST_FR_FIX:  state_in = ST_D_WEAK;
         ST_D_WEAK:  state_in = ST_D_LEFT;
         ST_D_LEFT:  state_in = ST_D_RIGHT;
         ST_D_RIGHT: state_in = ST_D_LAST;
         ST_D_LAST:  state_in = ST_DECIDE;
         ST_DECIDE: begin
            // no change: drop the item; otherwise wait for a free result slot
            if (!changed || load) state_in = ST_IDLE;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   rmds_mul u_mul (
      .clock (clock),
      .op    (mul_op),
      .prod  (prod)
   );

   rmds_mask u_mask (
      .drv     (drv_ff),
      .shadow  (shadow_ff),
      .quirks  (quirk_ff),
      .changed (changed),
      .item    (item)
   );

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         main_att_ff  <= '0;
         trig_att_ff  <= '0;
         trig_mode_ff <= '0;
         quirk_ff     <= '0;
         shadow_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_en) begin
            unique case (csr_index)
               rmds_pkg::CSR_MAIN_ATT:  main_att_ff  <= csr_wdata;
               rmds_pkg::CSR_TRIG_ATT:  trig_att_ff  <= csr_wdata;
               rmds_pkg::CSR_TRIG_MODE: trig_mode_ff <= csr_wdata[1:0];
               rmds_pkg::CSR_QUIRKS:    quirk_ff     <= csr_wdata[rmds_pkg::QUIRK_W-1:0];
               default: ;
            endcase
         end
         if (load) begin
            shadow_ff    <= drv_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         weak_ff   <= weak_gated;
         strong_ff <= strong_gated;
         max_ff    <= (weak_gated > strong_gated) ? weak_gated : strong_gated;
         pos_l_ff  <= req_data.left_trigger_position;
         pos_r_ff  <= req_data.right_trigger_position;
      end
      if (state_ff == ST_FL_MUL) ptrig_ff <= ptrig_now;
      if (state_ff == ST_FL_DIV || state_ff == ST_FR_DIV) begin
         num_ff <= prod[rmds_pkg::MUL_A_W-1:0];
      end
      if (state_ff == ST_FL_FIX)  frac_l_ff       <= frac_now;
      if (state_ff == ST_FR_FIX)  frac_r_ff       <= frac_now;
      if (state_ff == ST_D_WEAK)  drv_ff.strong_drv <= drive_now;
      if (state_ff == ST_D_LEFT)  drv_ff.weak_drv <= drive_now;
      if (state_ff == ST_D_RIGHT) drv_ff.left     <= drive_now;
      if (state_ff == ST_D_LAST)  drv_ff.right    <= drive_now;
      if (load)                   rsp_data_ff     <= item;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a new result only comes out of the compare step
   a_load_from_decide: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DECIDE))
      else $error("result loaded outside compare step");

   // shadows move only together with a result load
   a_shadow_on_load: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(shadow_ff)) |-> $past(load))
      else $error("shadow update without a result");

   // scaled fractions stay within percent range
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_D_WEAK) |-> (frac_l_ff <= rmds_pkg::PCT_FULL &&
                                   frac_r_ff <= rmds_pkg::PCT_FULL))
      else $error("trigger fraction above 100");

   // drives leaving the block are percentages
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.strong_drive <= rmds_pkg::PCT_FULL &&
                        rsp_data_ff.weak_drive <= rmds_pkg::PCT_FULL &&
                        rsp_data_ff.left_trigger_drive <= rmds_pkg::PCT_FULL &&
                        rsp_data_ff.right_trigger_drive <= rmds_pkg::PCT_FULL))
      else $error("drive above 100");

endmodule
